[design/bsm_pkg.sv]
// Shared types and constants for the bank switch mapper with scanline interrupt.
// Used by the controller, the datapath and the top level.
package bsm_pkg;

    localparam int CHR_SLOTS = 8;
    localparam int LANE_W = 8;
    localparam int PRG_BANK_W = 9;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_PRG_PAGE_COUNT = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHR_PAGE_COUNT = 4'd1;

    typedef struct packed {
        logic        action;
        logic [15:0] address;
        logic [7:0]  data;
    } item_t;

    typedef struct packed {
        logic [PRG_BANK_W-1:0]       prg_bank_a;
        logic [PRG_BANK_W-1:0]       prg_bank_b;
        logic [PRG_BANK_W-1:0]       prg_bank_c;
        logic [PRG_BANK_W-1:0]       prg_bank_d;
        logic [CHR_SLOTS*LANE_W-1:0] chr_banks;
        logic [1:0]                  mirror_mode;
        logic                        irq_request;
    } result_t;

    typedef struct packed {
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic load;
        logic step;
        logic commit;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_last;
    } ctl_status_t;

endpackage

[design/bsm_stream_if.sv]
// Valid/ready channel interface carrying one payload beat.
// The payload type is set per instance from the types in bsm_pkg.
interface bsm_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/bank_switch_mapper_with_scanline_irq_unit.sv]
// Bank switch mapper with scanline interrupt counter: each beat on cmd is one bus write or one
// scanline tick, and each gives exactly one result beat on rsp with the program and pattern bank
// mapping, the mirroring code and the interrupt request. After acceptance an item goes in order
// through these steps: apply the write, load the remainder lanes, run eight bit-serial steps of
// those lanes, commit the program bank and fill the output register.
// The result register lets the next beat be accepted while a result still waits on rsp.
// Configuration beats on cfg are always accepted and must be sent only while the block is idle.
module bank_switch_mapper_with_scanline_irq_unit (
    input  logic         clk,
    input  logic         rst_n,
    bsm_stream_if.sink   cmd,
    bsm_stream_if.source rsp,
    bsm_stream_if.sink   cfg
);
    bsm_pkg::ctl_cmd_t    ctl;
    bsm_pkg::ctl_status_t status;
    logic                 cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we = cfg.valid && cfg.ready;

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .ctl       (ctl),
        .status    (status)
    );

    bsm_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .status   (status),
        .item     (cmd.payload),
        .cfg_we   (cfg_we),
        .cfg_beat (cfg.payload),
        .result   (rsp.payload)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("block accepted a beat while still working on the previous one");

    a_commands_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.capture, ctl.apply, ctl.load, ctl.step, ctl.commit, ctl.emit}))
        else $error("more than one datapath command issued in one cycle");

    a_commit_after_divide: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> $past(ctl.step && status.div_last))
        else $error("program bank committed before the remainder lanes finished");

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.emit && rsp.valid) |-> rsp.ready)
        else $error("result register overwritten while a beat was still pending");
endmodule

[design/bsm_mod_lane.sv]
// One bit-serial remainder lane: reduces an 8-bit value by a divisor, one bit per step.
// Depends on bsm_pkg for the lane width.
module bsm_mod_lane #(
    parameter int DIVISOR_W = 12
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic                         step,
    input  logic [bsm_pkg::LANE_W-1:0]   dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic [bsm_pkg::LANE_W-1:0]   remainder
);
    localparam int CMP_W = (DIVISOR_W > bsm_pkg::LANE_W + 1) ? DIVISOR_W : bsm_pkg::LANE_W + 1;

    logic [bsm_pkg::LANE_W-1:0] num_reg, num_next;
    logic [bsm_pkg::LANE_W-1:0] rem_reg, rem_next;
    logic [CMP_W-1:0]           trial;
    logic [CMP_W-1:0]           divisor_ext;
    logic [CMP_W-1:0]           diff;

    always_comb
    begin
        trial = CMP_W'({rem_reg, num_reg[bsm_pkg::LANE_W-1]});
        divisor_ext = CMP_W'(divisor);
        diff = trial - divisor_ext;
        num_next = num_reg;
        rem_next = rem_reg;
        if (load)
        begin
            num_next = dividend;
            rem_next = '0;
        end
        else if (step)
        begin
            num_next = {num_reg[bsm_pkg::LANE_W-2:0], 1'b0};
            rem_next = (trial >= divisor_ext) ? diff[bsm_pkg::LANE_W-1:0]
                                              : trial[bsm_pkg::LANE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign remainder = (divisor == '0) ? '0 : rem_reg;
endmodule

[design/bsm_ctrl.sv]
// Sequencing controller: accepts a beat, steps the datapath through apply, load,
// divide, commit and emit, and owns the result valid flag. Depends on bsm_pkg.
module bsm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output bsm_pkg::ctl_cmd_t     ctl,
    input  bsm_pkg::ctl_status_t  status
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_LOAD,
        S_DIV,
        S_COMMIT,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                ctl.apply = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                ctl.load = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                ctl.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (ctl.emit)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
endmodule

[design/bsm_datapath.sv]
// Mapper datapath: bank, mirroring and interrupt registers, write decode, the
// remainder lanes and the result register. Depends on bsm_pkg and bsm_mod_lane.
module bsm_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bsm_pkg::ctl_cmd_t     ctl,
    output bsm_pkg::ctl_status_t  status,
    input  bsm_pkg::item_t        item,
    input  logic                  cfg_we,
    input  bsm_pkg::cfg_t         cfg_beat,
    output bsm_pkg::result_t      result
);
    localparam int PRG_SELECTS = 3;
    localparam int DIV_STEPS = bsm_pkg::LANE_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    localparam logic [15:0] ADDR_PRG_0 = 16'h8800;
    localparam logic [15:0] ADDR_PRG_1 = 16'hA800;
    localparam logic [15:0] ADDR_PRG_2 = 16'hA000;
    localparam logic [15:0] ADDR_LAYOUT = 16'h9008;
    localparam logic [15:0] ADDR_MIRROR = 16'h9800;
    localparam logic [15:0] ADDR_IRQ_LO = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_HI = 16'hF004;
    localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF008;
    localparam logic [3:0]  CHR_HI_FIRST = 4'hB;
    localparam logic [3:0]  CHR_HI_LAST = 4'hE;
    localparam logic [11:0] CHR_LO_LOW_A = 12'h000;
    localparam logic [11:0] CHR_LO_HIGH_A = 12'h004;
    localparam logic [11:0] CHR_LO_LOW_B = 12'h008;
    localparam logic [11:0] CHR_LO_HIGH_B = 12'h00C;
    localparam logic [7:0]  LAYOUT_TRIGGER = 8'h01;
    localparam logic [7:0]  MIRROR_MAX = 8'h03;
    localparam logic [15:0] IRQ_STEP = 16'd113;
    localparam int          IRQ_ENABLE_BIT = 1;
    localparam logic        ACT_TICK = 1'b1;

    localparam logic [1:0]  PRG_NONE = 2'd3;
    localparam logic [9:0]  PRG_COUNT_MAX = 10'd512;
    localparam logic [9:0]  PRG_COUNT_RESET = 10'd32;
    localparam logic [11:0] CHR_COUNT_RESET = 12'd256;

    logic [9:0]  prg_count_reg;
    logic [11:0] chr_count_reg;

    bsm_pkg::item_t item_reg;

    logic [bsm_pkg::LANE_W-1:0]     chr_select_reg [bsm_pkg::CHR_SLOTS];
    logic [bsm_pkg::LANE_W-1:0]     chr_select_next [bsm_pkg::CHR_SLOTS];
    logic [bsm_pkg::PRG_BANK_W-1:0] prg_select_reg [PRG_SELECTS];
    logic [bsm_pkg::PRG_BANK_W-1:0] prg_select_next [PRG_SELECTS];
    logic [15:0] irq_count_reg, irq_count_next;
    logic [7:0]  irq_control_reg, irq_control_next;
    logic [1:0]  mirror_code_reg, mirror_code_next;
    logic        irq_flag_reg, irq_flag_next;
    logic [1:0]  prg_target_reg, prg_target_next;
    logic [STEP_W-1:0] step_cnt_reg;

    logic [9:0]                     prg_eff;
    logic [bsm_pkg::PRG_BANK_W-1:0] prg_last0;
    logic [bsm_pkg::PRG_BANK_W-1:0] prg_last1;
    logic [3:0]                     addr_hi;
    logic [11:0]                    addr_lo;
    logic                           chr_hit;
    logic [2:0]                     chr_slot;
    logic [1:0]                     chr_pair;

    logic [bsm_pkg::LANE_W-1:0] prg_rem;
    logic [bsm_pkg::LANE_W-1:0] chr_rem [bsm_pkg::CHR_SLOTS];

    bsm_pkg::result_t result_reg, result_next;

    always_comb
    begin
        prg_eff = (prg_count_reg > PRG_COUNT_MAX) ? PRG_COUNT_MAX : prg_count_reg;
        prg_last0 = (prg_eff == '0) ? '0 : bsm_pkg::PRG_BANK_W'(prg_eff - 10'd1);
        prg_last1 = (prg_eff <= 10'd1) ? '0 : bsm_pkg::PRG_BANK_W'(prg_eff - 10'd2);
        addr_hi = item_reg.address[15:12];
        addr_lo = item_reg.address[11:0];
        chr_hit = (addr_hi >= CHR_HI_FIRST) && (addr_hi <= CHR_HI_LAST)
                  && ((addr_lo == CHR_LO_LOW_A) || (addr_lo == CHR_LO_HIGH_A)
                  || (addr_lo == CHR_LO_LOW_B) || (addr_lo == CHR_LO_HIGH_B));
        chr_pair = 2'(addr_hi - CHR_HI_FIRST);
        chr_slot = {chr_pair, addr_lo[3]};
    end

    always_comb
    begin
        chr_select_next = chr_select_reg;
        prg_select_next = prg_select_reg;
        irq_count_next = irq_count_reg;
        irq_control_next = irq_control_reg;
        mirror_code_next = mirror_code_reg;
        irq_flag_next = irq_flag_reg;
        prg_target_next = prg_target_reg;

        if (ctl.apply)
        begin
            irq_flag_next = 1'b0;
            prg_target_next = PRG_NONE;
            if (item_reg.action == ACT_TICK)
            begin
                if (irq_control_reg[IRQ_ENABLE_BIT])
                begin
                    if (irq_count_reg <= IRQ_STEP)
                    begin
                        irq_count_next = '0;
                        irq_flag_next = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg - IRQ_STEP;
                    end
                end
            end
            else if (chr_hit)
            begin
                if (addr_lo[2])
                begin
                    chr_select_next[chr_slot] = {item_reg.data[3:0],
                                                 chr_select_reg[chr_slot][3:0]};
                end
                else
                begin
                    chr_select_next[chr_slot] = {chr_select_reg[chr_slot][7:4],
                                                 item_reg.data[3:0]};
                end
            end
            else
            begin
                case (item_reg.address)
                    ADDR_PRG_0: prg_target_next = 2'd0;
                    ADDR_PRG_1: prg_target_next = 2'd1;
                    ADDR_PRG_2: prg_target_next = 2'd2;
                    ADDR_LAYOUT:
                    begin
                        if (item_reg.data == LAYOUT_TRIGGER)
                        begin
                            for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
                            begin
                                chr_select_next[i] = bsm_pkg::LANE_W'(i);
                            end
                            prg_select_next[0] = '0;
                            prg_select_next[1] = bsm_pkg::PRG_BANK_W'(1);
                            prg_select_next[2] = prg_last1;
                        end
                    end
                    ADDR_MIRROR:
                    begin
                        if (item_reg.data <= MIRROR_MAX)
                        begin
                            mirror_code_next = item_reg.data[1] ? item_reg.data[1:0]
                                                                : {1'b0, ~item_reg.data[0]};
                        end
                    end
                    ADDR_IRQ_LO: irq_count_next = {irq_count_reg[15:8], item_reg.data};
                    ADDR_IRQ_HI: irq_count_next = {item_reg.data, irq_count_reg[7:0]};
                    ADDR_IRQ_CTRL: irq_control_next = item_reg.data;
                    default: ;
                endcase
            end
        end

        if (ctl.commit && (prg_target_reg != PRG_NONE))
        begin
            prg_select_next[prg_target_reg] = bsm_pkg::PRG_BANK_W'(prg_rem);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= PRG_COUNT_RESET;
            chr_count_reg <= CHR_COUNT_RESET;
            for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
            begin
                chr_select_reg[i] <= bsm_pkg::LANE_W'(i);
            end
            prg_select_reg[0] <= '0;
            prg_select_reg[1] <= bsm_pkg::PRG_BANK_W'(1);
            prg_select_reg[2] <= bsm_pkg::PRG_BANK_W'(PRG_COUNT_RESET - 10'd2);
            irq_count_reg <= '0;
            irq_control_reg <= '0;
            mirror_code_reg <= '0;
            irq_flag_reg <= 1'b0;
            prg_target_reg <= PRG_NONE;
            step_cnt_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_beat.index)
                    bsm_pkg::REG_PRG_PAGE_COUNT: prg_count_reg <= cfg_beat.data[9:0];
                    bsm_pkg::REG_CHR_PAGE_COUNT: chr_count_reg <= cfg_beat.data;
                    default: ;
                endcase
            end
            chr_select_reg <= chr_select_next;
            prg_select_reg <= prg_select_next;
            irq_count_reg <= irq_count_next;
            irq_control_reg <= irq_control_next;
            mirror_code_reg <= mirror_code_next;
            irq_flag_reg <= irq_flag_next;
            prg_target_reg <= prg_target_next;
            if (ctl.load)
            begin
                step_cnt_reg <= '0;
            end
            else if (ctl.step)
            begin
                step_cnt_reg <= step_cnt_reg + 1'b1;
            end
        end
    end

    assign status.div_last = (step_cnt_reg == STEP_W'(DIV_STEPS - 1));

    bsm_mod_lane #(.DIVISOR_W(10)) u_prg_lane (
        .clk       (clk),
        .load      (ctl.load),
        .step      (ctl.step),
        .dividend  (item_reg.data),
        .divisor   (prg_eff),
        .remainder (prg_rem)
    );

    for (genvar g = 0; g < bsm_pkg::CHR_SLOTS; g++)
    begin : g_chr_lane
        bsm_mod_lane #(.DIVISOR_W(12)) u_chr_lane (
            .clk       (clk),
            .load      (ctl.load),
            .step      (ctl.step),
            .dividend  (chr_select_reg[g]),
            .divisor   (chr_count_reg),
            .remainder (chr_rem[g])
        );
    end

    always_comb
    begin
        result_next = result_reg;
        if (ctl.emit)
        begin
            result_next.prg_bank_a = prg_select_reg[0];
            result_next.prg_bank_b = prg_select_reg[1];
            result_next.prg_bank_c = prg_select_reg[2];
            result_next.prg_bank_d = prg_last0;
            for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
            begin
                result_next.chr_banks[i*bsm_pkg::LANE_W +: bsm_pkg::LANE_W] = chr_rem[i];
            end
            result_next.mirror_mode = mirror_code_reg;
            result_next.irq_request = irq_flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            item_reg <= item;
        end
        result_reg <= result_next;
    end

    assign result = result_reg;
endmodule

[tb/tb_bank_switch_mapper_with_scanline_irq_unit.sv]
// Self-checking testbench for the bank switch mapper with scanline interrupt counter.
// Drives bus writes and scanline ticks against a built-in predictor across several
// page count settings. Depends on bsm_pkg and the bsm_stream_if channel interface.
module tb_bank_switch_mapper_with_scanline_irq_unit;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic [15:0] ADDR_PRG_A = 16'h8800;
    localparam logic [15:0] ADDR_PRG_B = 16'hA800;
    localparam logic [15:0] ADDR_PRG_C = 16'hA000;
    localparam logic [15:0] ADDR_CHR_BASE = 16'hB000;
    localparam logic [15:0] ADDR_LAYOUT = 16'h9008;
    localparam logic [15:0] ADDR_MIRROR = 16'h9800;
    localparam logic [15:0] ADDR_IRQ_LO = 16'hF000;
    localparam logic [15:0] ADDR_IRQ_HI = 16'hF004;
    localparam logic [15:0] ADDR_IRQ_CTL = 16'hF008;
    localparam logic [3:0] CHR_PAGE_FIRST = 4'hB;
    localparam logic [3:0] CHR_PAGE_LAST = 4'hE;

    localparam logic [7:0] LAYOUT_RESTORE = 8'h01;
    localparam logic [7:0] MIRROR_MAX = 8'h03;
    localparam int IRQ_ENABLE_BIT = 1;
    localparam logic [15:0] IRQ_STEP = 16'd113;
    localparam int PRG_CLAMP = 512;

    localparam logic [bsm_pkg::CFG_INDEX_W-1:0] REG_SPARE = 4'hF;

    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 188;
    localparam int TAIL_CYCLES = 20;
    localparam int STALL_LIMIT = 5000;
    localparam int PRINT_CAP = 50;

    localparam bsm_pkg::result_t RESET_MAP = '{
        prg_bank_a: 9'd0,
        prg_bank_b: 9'd1,
        prg_bank_c: 9'd30,
        prg_bank_d: 9'd31,
        chr_banks: 64'h0706050403020100,
        mirror_mode: 2'd0,
        irq_request: 1'b0
    };

    typedef struct {
        bsm_pkg::item_t   beat;
        bit               typed;
        bsm_pkg::result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    bsm_stream_if #(.payload_t(bsm_pkg::item_t)) cmd_if ();
    bsm_stream_if #(.payload_t(bsm_pkg::result_t)) rsp_if ();
    bsm_stream_if #(.payload_t(bsm_pkg::cfg_t)) cfg_if ();

    bank_switch_mapper_with_scanline_irq_unit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_if),
        .rsp(rsp_if),
        .cfg(cfg_if)
    );

    logic [9:0] cnt_prg_pages;
    logic [11:0] cnt_chr_pages;
    logic [7:0] bank_chr_sel [bsm_pkg::CHR_SLOTS];
    logic [8:0] bank_prg_sel [3];
    logic [15:0] scan_count;
    logic [7:0] scan_ctrl;
    logic [1:0] mirror_sel;

    bsm_pkg::result_t pending_maps [$];
    stim_row_t stim_table [$];
    int mismatch_count = 0;
    int stall_cycles = 0;
    bit steady = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(12, 40);
    endfunction

    function automatic int unsigned eff_prg_pages();
        return (cnt_prg_pages > PRG_CLAMP) ? PRG_CLAMP : cnt_prg_pages;
    endfunction

    function automatic logic [8:0] prg_tail(int unsigned back);
        int unsigned c;
        c = eff_prg_pages();
        return (c <= back) ? 9'd0 : 9'(c - 1 - back);
    endfunction

    function automatic logic [8:0] prg_reduce(logic [7:0] value);
        int unsigned c;
        c = eff_prg_pages();
        return (c == 0) ? 9'd0 : 9'(value % c);
    endfunction

    function automatic void restore_layout();
        for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
        begin
            bank_chr_sel[i] = 8'(i);
        end
        bank_prg_sel[0] = 9'd0;
        bank_prg_sel[1] = 9'd1;
        bank_prg_sel[2] = prg_tail(1);
    endfunction

    function automatic void reset_mapping();
        cnt_prg_pages = 10'd32;
        cnt_chr_pages = 12'd256;
        scan_count = '0;
        scan_ctrl = '0;
        mirror_sel = '0;
        restore_layout();
    endfunction

    function automatic void apply_register(bsm_pkg::cfg_t w);
        if (w.index == bsm_pkg::REG_PRG_PAGE_COUNT)
        begin
            cnt_prg_pages = w.data[9:0];
        end
        else if (w.index == bsm_pkg::REG_CHR_PAGE_COUNT)
        begin
            cnt_chr_pages = w.data;
        end
    endfunction

    function automatic bsm_pkg::result_t compute_mapping(bsm_pkg::item_t it);
        bsm_pkg::result_t res;
        logic [3:0] page_hi;
        logic [11:0] page_lo;
        logic [2:0] slot;
        int unsigned c;
        page_hi = it.address[15:12];
        page_lo = it.address[11:0];
        res.irq_request = 1'b0;
        if (it.action == ACT_TICK)
        begin
            if (scan_ctrl[IRQ_ENABLE_BIT])
            begin
                if (scan_count <= IRQ_STEP)
                begin
                    scan_count = '0;
                    res.irq_request = 1'b1;
                end
                else
                begin
                    scan_count = scan_count - IRQ_STEP;
                end
            end
        end
        else if (page_hi >= CHR_PAGE_FIRST && page_hi <= CHR_PAGE_LAST
                 && page_lo[11:4] == '0 && page_lo[1:0] == '0)
        begin
            slot = {2'(page_hi - CHR_PAGE_FIRST), page_lo[3]};
            if (page_lo[2])
            begin
                bank_chr_sel[slot][7:4] = it.data[3:0];
            end
            else
            begin
                bank_chr_sel[slot][3:0] = it.data[3:0];
            end
        end
        else
        begin
            case (it.address)
                ADDR_PRG_A: bank_prg_sel[0] = prg_reduce(it.data);
                ADDR_PRG_B: bank_prg_sel[1] = prg_reduce(it.data);
                ADDR_PRG_C: bank_prg_sel[2] = prg_reduce(it.data);
                ADDR_LAYOUT:
                begin
                    if (it.data == LAYOUT_RESTORE)
                    begin
                        restore_layout();
                    end
                end
                ADDR_MIRROR:
                begin
                    if (it.data <= MIRROR_MAX)
                    begin
                        mirror_sel = (it.data == 8'd0) ? 2'd1 :
                                     (it.data == 8'd1) ? 2'd0 : it.data[1:0];
                    end
                end
                ADDR_IRQ_LO: scan_count[7:0] = it.data;
                ADDR_IRQ_HI: scan_count[15:8] = it.data;
                ADDR_IRQ_CTL: scan_ctrl = it.data;
                default: ;
            endcase
        end
        c = cnt_chr_pages;
        for (int i = 0; i < bsm_pkg::CHR_SLOTS; i++)
        begin
            res.chr_banks[8*i +: 8] = (c == 0) ? 8'd0 : 8'(bank_chr_sel[i] % c);
        end
        res.prg_bank_a = bank_prg_sel[0];
        res.prg_bank_b = bank_prg_sel[1];
        res.prg_bank_c = bank_prg_sel[2];
        res.prg_bank_d = prg_tail(0);
        res.mirror_mode = mirror_sel;
        return res;
    endfunction

    function automatic bsm_pkg::item_t bus_beat(logic act, logic [15:0] addr, logic [7:0] value);
        bsm_pkg::item_t it;
        it.action = act;
        it.address = addr;
        it.data = value;
        return it;
    endfunction

    function automatic logic [15:0] chr_addr(logic [2:0] slot, bit upper);
        return ADDR_CHR_BASE + {2'b00, slot[2:1], 12'h000}
               + (slot[0] ? 16'h0008 : 16'h0000) + (upper ? 16'h0004 : 16'h0000);
    endfunction

    function automatic bsm_pkg::item_t random_bus_item();
        int unsigned r;
        logic [15:0] addr;
        logic [7:0] value;
        r = $urandom_range(0, 99);
        value = 8'($urandom_range(0, 255));
        addr = 16'($urandom_range(0, 65535));
        if (r < 28)
        begin
            return bus_beat(ACT_TICK, addr, value);
        end
        if (r < 40)
        begin
            case ($urandom_range(0, 2))
                0: addr = ADDR_PRG_A;
                1: addr = ADDR_PRG_B;
                default: addr = ADDR_PRG_C;
            endcase
        end
        else if (r < 58)
        begin
            addr = chr_addr(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
        end
        else if (r < 62)
        begin
            addr = ADDR_LAYOUT;
            if ($urandom_range(0, 3) != 0)
            begin
                value = LAYOUT_RESTORE;
            end
        end
        else if (r < 67)
        begin
            addr = ADDR_MIRROR;
            if ($urandom_range(0, 4) != 0)
            begin
                value = 8'($urandom_range(0, 3));
            end
        end
        else if (r < 77)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                addr = ADDR_IRQ_LO;
            end
            else
            begin
                addr = ADDR_IRQ_HI;
                if ($urandom_range(0, 4) != 0)
                begin
                    value = 8'($urandom_range(0, 3));
                end
            end
        end
        else if (r < 82)
        begin
            addr = ADDR_IRQ_CTL;
            if ($urandom_range(0, 4) != 0)
            begin
                value[IRQ_ENABLE_BIT] = 1'b1;
            end
        end
        else if (r >= 92)
        begin
            addr = {4'($urandom_range(CHR_PAGE_FIRST, CHR_PAGE_LAST)),
                    12'($urandom_range(0, 15))};
        end
        return bus_beat(ACT_WRITE, addr, value);
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("ERROR at %0t: %s: got %h, expected %h", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic drive_cmd(bsm_pkg::item_t it, bit typed, bsm_pkg::result_t want);
        int unsigned gap;
        bsm_pkg::result_t model;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.payload <= it;
        do @(posedge clk); while (cmd_if.ready !== 1'b1);
        model = compute_mapping(it);
        pending_maps.push_back(typed ? want : model);
        @(negedge clk);
    endtask

    task automatic drain_mappings();
        cmd_if.valid <= 1'b0;
        do @(negedge clk); while (pending_maps.size() != 0);
    endtask

    task automatic write_regs(logic [11:0] prg_val, logic [11:0] chr_val, bit spare);
        bsm_pkg::cfg_t beats [$];
        beats.push_back('{index: bsm_pkg::REG_PRG_PAGE_COUNT, data: prg_val});
        beats.push_back('{index: bsm_pkg::REG_CHR_PAGE_COUNT, data: chr_val});
        if (spare)
        begin
            beats.push_back('{index: REG_SPARE, data: 12'hABC});
        end
        foreach (beats[i])
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.payload <= beats[i];
            do @(posedge clk); while (cfg_if.ready !== 1'b1);
            apply_register(beats[i]);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_row(logic act, logic [15:0] addr, logic [7:0] value, bit typed);
        stim_row_t row;
        row.beat = bus_beat(act, addr, value);
        row.typed = typed;
        row.want = RESET_MAP;
        stim_table.push_back(row);
    endtask

    task automatic run_random(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i == count / 2)
            begin
                drain_mappings();
            end
            drive_cmd(random_bus_item(), 1'b0, RESET_MAP);
        end
    endtask

    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            int unsigned gap;
            @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        bsm_pkg::result_t want;
        bsm_pkg::result_t got;
        if (rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = rsp_if.payload;
            if (pending_maps.size() == 0)
            begin
                report("result beat with nothing pending", got.chr_banks, 64'd0);
            end
            else
            begin
                want = pending_maps.pop_front();
                if (got.prg_bank_a !== want.prg_bank_a)
                    report("prg_bank_a", 64'(got.prg_bank_a), 64'(want.prg_bank_a));
                if (got.prg_bank_b !== want.prg_bank_b)
                    report("prg_bank_b", 64'(got.prg_bank_b), 64'(want.prg_bank_b));
                if (got.prg_bank_c !== want.prg_bank_c)
                    report("prg_bank_c", 64'(got.prg_bank_c), 64'(want.prg_bank_c));
                if (got.prg_bank_d !== want.prg_bank_d)
                    report("prg_bank_d", 64'(got.prg_bank_d), 64'(want.prg_bank_d));
                if (got.chr_banks !== want.chr_banks)
                    report("chr_banks", got.chr_banks, want.chr_banks);
                if (got.mirror_mode !== want.mirror_mode)
                    report("mirror_mode", 64'(got.mirror_mode), 64'(want.mirror_mode));
                if (got.irq_request !== want.irq_request)
                    report("irq_request", 64'(got.irq_request), 64'(want.irq_request));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [11:0] prg_plan [6];
        logic [11:0] chr_plan [6];
        logic [11:0] prg_val;
        logic [11:0] chr_val;
        prg_plan = '{12'd2, 12'd512, 12'hFFF, 12'd0, 12'd1, 12'd513};
        chr_plan = '{12'd0, 12'd2048, 12'hFFF, 12'd1, 12'd255, 12'd256};
        rst_n = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        reset_mapping();

        // The first two beats see the reset mapping; the tick does nothing with
        // the interrupt control byte still clear.
        add_row(ACT_WRITE, 16'h0000, 8'h00, 1'b1);
        add_row(ACT_TICK, 16'hFFFF, 8'hFF, 1'b1);
        add_row(ACT_WRITE, ADDR_PRG_A, 8'hFF, 1'b0);
        add_row(ACT_WRITE, ADDR_PRG_B, 8'h00, 1'b0);
        add_row(ACT_WRITE, ADDR_PRG_C, 8'h80, 1'b0);
        add_row(ACT_WRITE, chr_addr(3'd0, 1'b0), 8'hFF, 1'b0);
        add_row(ACT_WRITE, chr_addr(3'd0, 1'b1), 8'h0A, 1'b0);
        add_row(ACT_WRITE, chr_addr(3'd7, 1'b0), 8'h0F, 1'b0);
        add_row(ACT_WRITE, chr_addr(3'd7, 1'b1), 8'hF3, 1'b0);
        add_row(ACT_WRITE, chr_addr(3'd4, 1'b1), 8'h5C, 1'b0);
        add_row(ACT_WRITE, ADDR_CHR_BASE + 16'h0001, 8'h77, 1'b0);
        add_row(ACT_WRITE, ADDR_MIRROR, 8'h00, 1'b0);
        add_row(ACT_WRITE, ADDR_MIRROR, 8'h04, 1'b0);
        add_row(ACT_WRITE, ADDR_MIRROR, 8'h03, 1'b0);
        add_row(ACT_WRITE, ADDR_IRQ_LO, 8'hE3, 1'b0);
        add_row(ACT_WRITE, ADDR_IRQ_HI, 8'h00, 1'b0);
        add_row(ACT_WRITE, ADDR_IRQ_CTL, 8'h02, 1'b0);
        add_row(ACT_TICK, 16'h0000, 8'h00, 1'b0);
        add_row(ACT_TICK, 16'h0000, 8'h00, 1'b0);
        add_row(ACT_TICK, 16'h0000, 8'h00, 1'b0);
        add_row(ACT_WRITE, ADDR_IRQ_LO, 8'h71, 1'b0);
        add_row(ACT_TICK, 16'h5555, 8'hAA, 1'b0);
        add_row(ACT_WRITE, ADDR_LAYOUT, 8'h02, 1'b0);
        add_row(ACT_WRITE, ADDR_LAYOUT, LAYOUT_RESTORE, 1'b0);
        add_row(ACT_WRITE, ADDR_IRQ_CTL, 8'hFD, 1'b0);
        add_row(ACT_TICK, 16'h0000, 8'h00, 1'b0);

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_table[i])
        begin
            drive_cmd(stim_table[i].beat, stim_table[i].typed, stim_table[i].want);
        end
        run_random(ITEMS_PER_PHASE);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain_mappings();
            if (ph < 6)
            begin
                prg_val = prg_plan[ph];
                chr_val = chr_plan[ph];
            end
            else
            begin
                prg_val = 12'($urandom_range(2, 512));
                chr_val = 12'($urandom_range(0, 2048));
            end
            write_regs(prg_val, chr_val, ph == 0);
            steady = (ph % 2 == 1);
            run_random(ITEMS_PER_PHASE);
        end

        steady = 1'b0;
        drain_mappings();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_maps.size() != 0)
        begin
            report("results still pending at the end", 64'(pending_maps.size()), 64'd0);
        end
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
